/* src/indexed_insert_delete_list_top_assert.svh */
// ----------------------------------------------------------------------------
// Indexed list assertion macros
// Shared assertion forms for the indexed insert/delete list.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_LIST_TOP_ASSERT_SVH
`define INDEXED_INSERT_DELETE_LIST_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define IIDL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed list assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define IIDL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexed list assertion failed");

`endif

/* src/iidl_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list package
// Opcodes, status codes, shared types and the group priority encoder.
// ----------------------------------------------------------------------------
package iidl_pkg;

	// operation codes (input tuser)
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_FIND   = 2'd3;

	// result status codes (output tuser)
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// cells examined per find cycle
	localparam int GRP = 16;

	// control broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

	// first hit within one group
	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} grp_hit_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	// lowest set bit of a 16-bit group
	function automatic grp_hit_t first_hit(input logic [GRP-1:0] bits);
		grp_hit_t r;
		r = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (bits[i]) begin
				r.hit = 1'b1;
				r.idx = 4'(i);
			end
		end
		return r;
	endfunction

endpackage

/* src/iidl_cell.sv */
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one list entry; shifts from its lower or upper neighbor on insert
// or delete, and reports read selection and find matches.
// ----------------------------------------------------------------------------
module iidl_cell #(
	parameter int IDX   = 0,
	parameter int XW    = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iidl_pkg::cell_cmd_t  cmd,
	input  logic [XW-1:0]        pos,
	input  logic [XW-1:0]        cnt,
	input  logic [31:0]          ins_val,
	input  logic [31:0]          find_val,
	input  logic [31:0]          prev_entry,
	input  logic [31:0]          next_entry,
	output logic [31:0]          entry,
	output logic [31:0]          rd_data,
	output logic                 match
);

	localparam logic [XW-1:0] ME      = XW'(IDX);
	localparam logic [XW-1:0] ME_NEXT = XW'(IDX + 1);

	logic [31:0] entry_q;

	// insert: take the new value at the position, shift up above it
	// delete: shift down from the position, clear the vacated top entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (cmd.ins) begin
			if (pos == ME) begin
				entry_q <= ins_val;
			end else if (ME > pos && ME <= cnt) begin
				entry_q <= prev_entry;
			end
		end else if (cmd.del) begin
			if (ME >= pos && ME < cnt) begin
				entry_q <= (ME_NEXT < cnt) ? next_entry : '0;
			end
		end
	end

	assign entry   = entry_q;
	assign rd_data = (pos == ME) ? entry_q : '0;
	assign match   = (entry_q == find_val) && (ME < cnt);

endmodule

/* src/indexed_insert_delete_list_top.sv */
// ----------------------------------------------------------------------------
// Indexed insert/delete list
// Packed ordered list of signed 32-bit entries in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel s_*: tuser carries the opcode (insert, delete, read, find),
//  tdata the position and value. Output channel m_*: tuser carries the
//  status, tdata the data, found flag, found position and list length.
//  Every input transfer yields exactly one output transfer, in order.
//  Insert, delete and read finish in the cycle of the input transfer; the
//  result is registered and shows on m_tvalid the next cycle, so these
//  run at one item per clock while m_tready does not hold the output.
//  Find compares all cells at once but resolves the first hit over groups
//  of 16 cells, one group per cycle, up to the first group with a hit or
//  the last group; during the scan s_tready stays low.
//  A waiting result does not stop a new transfer if m_tready takes it in
//  the same cycle; while the output register is full and m_tready is low,
//  s_tready is low and a finished find holds until the register frees.
//  Reset empties the list and clears all entries to zero; no clearing pass.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_top #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [4:0] position, [36:5] value, zero pad
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] data_out, [32] found,
	                               // [36:33] found_position, [41:37] list_length
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 5) ? CW : 5;
	localparam int NG = (DEPTH + iidl_pkg::GRP - 1) / iidl_pkg::GRP;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
	localparam logic [GW-1:0] LAST_G  = GW'(NG - 1);

	iidl_pkg::state_t    state_q;
	logic [CW-1:0]       count_q;
	logic [31:0]         find_val_q;
	logic [GW-1:0]       grp_q;
	logic                m_valid_q;
	logic [1:0]          res_status_q;
	logic [31:0]         res_data_q;
	logic                res_found_q;
	logic [3:0]          res_fpos_q;
	logic [4:0]          res_len_q;

	logic [1:0]          op;
	logic [4:0]          pos;
	logic [31:0]         val;
	logic [XW-1:0]       pos_x;
	logic [XW-1:0]       cnt_x;
	logic                out_free;
	logic                acc;
	logic                ins_ok;
	logic                del_ok;
	logic                rd_ok;
	iidl_pkg::cell_cmd_t cmd;
	logic [XW-1:0]       cnt_next;
	logic [31:0]         rd_or;
	logic [31:0]         ent [DEPTH];
	logic [31:0]         rd  [DEPTH];
	logic [DEPTH-1:0]    mt;
	logic [NG*iidl_pkg::GRP-1:0] match_pad;
	iidl_pkg::grp_hit_t  gh;
	logic                scan_done;
	logic                load_imm;
	logic                load_find;
	logic [1:0]          imm_status;

	// input unpacking
	assign op    = s_tuser;
	assign pos   = s_tdata[4:0];
	assign val   = s_tdata[36:5];
	assign pos_x = XW'(pos);
	assign cnt_x = XW'(count_q);

	// handshake
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == iidl_pkg::S_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;

	// range and fill checks
	assign ins_ok = (op == iidl_pkg::OP_INSERT) && (pos_x <= cnt_x) && (cnt_x != DEPTH_X);
	assign del_ok = (op == iidl_pkg::OP_DELETE) && (pos_x < cnt_x);
	assign rd_ok  = (op == iidl_pkg::OP_READ) && (pos_x < cnt_x);

	assign cmd.ins = acc && ins_ok;
	assign cmd.del = acc && del_ok;

	always_comb begin
		cnt_next = cnt_x;
		if (cmd.ins) begin
			cnt_next = cnt_x + XW'(1);
		end else if (cmd.del) begin
			cnt_next = cnt_x - XW'(1);
		end
	end

	always_comb begin
		imm_status = iidl_pkg::ST_OK;
		if (op == iidl_pkg::OP_INSERT) begin
			if (pos_x > cnt_x) begin
				imm_status = iidl_pkg::ST_RANGE;
			end else if (cnt_x == DEPTH_X) begin
				imm_status = iidl_pkg::ST_FULL;
			end
		end else if (op != iidl_pkg::OP_FIND && pos_x >= cnt_x) begin
			imm_status = iidl_pkg::ST_RANGE;
		end
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] prev_e;
		logic [31:0] next_e;
		if (i == 0) begin : g_first
			assign prev_e = '0;
		end else begin : g_mid
			assign prev_e = ent[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_nxt
			assign next_e = ent[i+1];
		end
		iidl_cell #(
			.IDX   (i),
			.XW    (XW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.pos        (pos_x),
			.cnt        (cnt_x),
			.ins_val    (val),
			.find_val   (find_val_q),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (ent[i]),
			.rd_data    (rd[i]),
			.match      (mt[i])
		);
	end

	// read select: only the addressed cell drives nonzero
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | rd[i];
		end
	end

	// find: pad match vector to whole groups, encode the current group
	always_comb begin
		match_pad = '0;
		match_pad[DEPTH-1:0] = mt;
	end

	assign gh        = iidl_pkg::first_hit(match_pad[grp_q*iidl_pkg::GRP +: iidl_pkg::GRP]);
	assign scan_done = gh.hit || (grp_q == LAST_G);
	assign load_imm  = acc && (op != iidl_pkg::OP_FIND);
	assign load_find = (state_q == iidl_pkg::S_SCAN) && scan_done && out_free;

	// control: state, count, scan group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iidl_pkg::S_IDLE;
			count_q <= '0;
			grp_q   <= '0;
		end else begin
			count_q <= CW'(cnt_next);
			unique case (state_q)
				iidl_pkg::S_IDLE: begin
					if (acc && op == iidl_pkg::OP_FIND) begin
						state_q <= iidl_pkg::S_SCAN;
						grp_q   <= '0;
					end
				end
				iidl_pkg::S_SCAN: begin
					if (load_find) begin
						state_q <= iidl_pkg::S_IDLE;
					end else if (!scan_done) begin
						grp_q <= grp_q + GW'(1);
					end
				end
				default: begin
					state_q <= iidl_pkg::S_IDLE;
				end
			endcase
		end
	end

	// search value held through the scan
	always_ff @(posedge clk) begin
		if (acc && op == iidl_pkg::OP_FIND) begin
			find_val_q <= val;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_imm || load_find) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_imm) begin
			res_status_q <= imm_status;
			res_data_q   <= (del_ok || rd_ok) ? rd_or : '0;
			res_found_q  <= 1'b0;
			res_fpos_q   <= '0;
			res_len_q    <= cnt_next[4:0];
		end else if (load_find) begin
			res_status_q <= iidl_pkg::ST_OK;
			res_data_q   <= '0;
			res_found_q  <= gh.hit;
			res_fpos_q   <= gh.hit ? gh.idx : 4'd0;
			res_len_q    <= cnt_x[4:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = {6'd0, res_len_q, res_fpos_q, res_found_q, res_data_q};

	// assertions
	`include "indexed_insert_delete_list_top_assert.svh"

	`IIDL_ASSERT_NOW(a_count_bound, 1'b1, cnt_x <= DEPTH_X)
	`IIDL_ASSERT_NOW(a_full_only_when_full, load_imm && imm_status == iidl_pkg::ST_FULL, cnt_x == DEPTH_X)
	`IIDL_ASSERT_NOW(a_no_accept_in_scan, state_q == iidl_pkg::S_SCAN, !s_tready)
	`IIDL_ASSERT_NEXT(a_delete_shrinks, cmd.del, count_q == $past(count_q) - CW'(1))

endmodule
